// ----- sv/lrt_pkg.sv -----
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared codes, saturation helpers and the sigmoid table generator.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TRAIN = 2'd1;
  localparam logic [1:0] ACT_PRED  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_PRED   = 1'b1;

  localparam logic [1:0] REG_LR   = 2'd0;
  localparam logic [1:0] REG_ITER = 2'd1;
  localparam logic [1:0] REG_FC   = 2'd2;

  localparam logic [15:0] LR_RST   = 16'd655;
  localparam logic [15:0] ITER_RST = 16'd100;
  localparam logic [3:0]  FC_RST   = 4'd8;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if ((v[42:31] == '0) || (v[42:31] == '1)) begin
      return v[31:0];
    end
    return v[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], n[k]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] sig_entry(input int unsigned i, input int unsigned depth);
    logic [63:0] num;
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] den;
    logic [63:0] p;
    logic signed [63:0] t;
    num = 64'(2 * i + 1) * 64'd524288;
    t   = signed'(udiv64(num, 64'(depth))) - 64'sd524288;
    a   = (t < 0) ? 64'(-t) : 64'(t);
    r   = (64'd1 << 31) - (a << 5);
    for (int k = 0; k < 10; k++) begin
      r = (r * r) >> 31;
    end
    den = (64'd1 << 31) + r;
    p   = udiv64((64'd1 << 47) + (den >> 1), den);
    return (t >= 0) ? 17'(p) : 17'(64'd65536 - p);
  endfunction

endpackage

// ----- sv/lrt_ram.sv -----
// ----------------------------------------------------------------------------
// lrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/lrt_sigmoid.sv -----
// ----------------------------------------------------------------------------
// lrt_sigmoid
// Two-stage sigmoid lookup: bin index from a Q24.24 sum, then table read.
// ----------------------------------------------------------------------------
module lrt_sigmoid #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic signed [47:0] z,
  output logic [16:0]        sig_r
);
  import lrt_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam logic signed [47:0] LIM = 48'sh0000_0800_0000;

  logic [16:0]    tbl [DEPTH];
  logic [27:0]    off;
  logic [63:0]    scaled;
  logic [IW-1:0]  idx_nxt;
  logic [IW-1:0]  idx_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_tbl
    localparam logic [16:0] ENTRY = sig_entry(i, DEPTH);
    assign tbl[i] = ENTRY;
  end

  assign off    = 28'(z + LIM);
  assign scaled = 64'(off) * 64'(DEPTH);

  always_comb begin
    if (z < -LIM) begin
      idx_nxt = '0;
    end else if (z >= LIM) begin
      idx_nxt = IW'(DEPTH - 1);
    end else begin
      idx_nxt = scaled[28 +: IW];
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sig_r <= tbl[idx_r];
  end

endmodule

// ----- sv/logistic_regression_trainer.sv -----
// ----------------------------------------------------------------------------
// logistic_regression_trainer
// Batch gradient descent logistic regression over a sample memory.
//
//   channel | dir | fields
//   in_*    | in  | tdata: feature_value, label; tuser: action; tlast: eos
//   out_*   | out | tdata: weight_value, weight_index, prediction;
//           |     | tuser: result_kind; tlast: last_result
//   cfg_*   | in  | APB: learning_rate, iteration_count, feature_count
//
// Load: one word per cycle while idle; a short sample is then zero-filled
// at each missing position. Predict: each word is multiplied, then added
// in ST_PACC before the next word is taken. Train: iteration_count passes
// over the samples via the single sample-memory read port, then n+1 words.
// Reset is synchronous; weights clear, memories need no clearing pass.
// Input is held off during weight output and while a result word stalls.
// ----------------------------------------------------------------------------
module logistic_regression_trainer #(
  parameter int MAX_SAMPLES         = 1024,
  parameter int MAX_FEATURES        = 8,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // feature_value[15:0], label[16], zero[23:17]
  input  logic [1:0]  in_tuser,   // action[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // weight_value[31:0], weight_index[35:32],
                                  // prediction[36], zero[39:37]
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lrt_pkg::*;

  localparam int MS  = MAX_SAMPLES;
  localparam int MF  = MAX_FEATURES;
  localparam int PW  = $clog2(MF + 1);
  localparam int SW  = $clog2(MS + 1);
  localparam int AW  = (MS * MF > 1) ? $clog2(MS * MF) : 1;
  localparam int LAW = (MS > 1) ? $clog2(MS) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FILL  = 4'd1;
  localparam logic [3:0] ST_PACC  = 4'd2;
  localparam logic [3:0] ST_TINIT = 4'd3;
  localparam logic [3:0] ST_ITER  = 4'd4;
  localparam logic [3:0] ST_SAMP  = 4'd5;
  localparam logic [3:0] ST_DRD   = 4'd6;
  localparam logic [3:0] ST_DMUL  = 4'd7;
  localparam logic [3:0] ST_DACC  = 4'd8;
  localparam logic [3:0] ST_SIG0  = 4'd9;
  localparam logic [3:0] ST_SIG1  = 4'd10;
  localparam logic [3:0] ST_SIG2  = 4'd11;
  localparam logic [3:0] ST_GRD   = 4'd12;
  localparam logic [3:0] ST_GMUL  = 4'd13;
  localparam logic [3:0] ST_GACC  = 4'd14;
  localparam logic [3:0] ST_UPD   = 4'd15;

  logic [3:0]  state_r, state_nxt;
  logic        upd_acc_r, upd_acc_nxt;
  logic        emit_r, emit_nxt;

  logic [15:0] lr_r;
  logic [15:0] iter_r;
  logic [3:0]  fc_r;

  logic [PW-1:0]      pos_r, pos_nxt;
  logic [SW-1:0]      loaded_r, loaded_nxt;
  logic [AW-1:0]      lbase_r, lbase_nxt;
  logic signed [47:0] psum_r, psum_nxt;
  logic               peos_r, peos_nxt;
  logic [PW-1:0]      j_r, j_nxt;
  logic [15:0]        it_r, it_nxt;
  logic [SW-1:0]      s_r, s_nxt;
  logic [AW-1:0]      tbase_r, tbase_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [47:0] mul_r, mul_nxt;
  logic signed [17:0] err_r, err_nxt;
  logic [39:0]        plo_r, plo_nxt;
  logic signed [40:0] phi_r, phi_nxt;

  logic               out_v_r, out_v_nxt;
  logic [31:0]        out_w_r, out_w_nxt;
  logic [3:0]         out_i_r, out_i_nxt;
  logic               out_p_r, out_p_nxt;
  logic               out_k_r, out_k_nxt;
  logic               out_l_r, out_l_nxt;

  logic signed [31:0] w_r [MF + 1];
  logic signed [47:0] g_r [MF + 1];
  logic               w_clr, w_we, g_clr, g_we;
  logic signed [31:0] w_wd;
  logic signed [47:0] g_wd;

  logic               ram_we, ram_re, lram_we, lram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;
  logic               lbl_rd;

  logic [PW-1:0]      n_c, widx, jm1;
  logic signed [31:0] w_rd;
  logic signed [47:0] g_rd;
  logic signed [15:0] x_in, opnd;
  logic               in_acc, out_free, cfg_wr;
  logic [16:0]        sig;
  logic signed [47:0] sum48;
  logic               full, pos_lt;

  assign x_in     = signed'(in_tdata[15:0]);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_v_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && !emit_r && out_free;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  assign n_c  = (32'(fc_r) < MF) ? PW'(fc_r) : PW'(MF);
  assign widx = (state_r == ST_IDLE) ? ((pos_r < n_c) ? PW'(pos_r + 1'b1) : '0) : j_r;
  assign w_rd = w_r[widx];
  assign g_rd = g_r[j_r];
  assign jm1  = PW'(j_r - 1'b1);
  assign opnd = (j_r == '0) ? 16'sd256 : signed'(ram_rdata);
  assign full   = !(32'(loaded_r) < MS);
  assign pos_lt = 32'(pos_r) < MF;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_p_r, out_i_r, out_w_r};
  assign out_tuser  = out_k_r;
  assign out_tlast  = out_l_r;

  lrt_ram #(.WIDTH(16), .DEPTH(MS * MF)) u_sample_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lrt_ram #(.WIDTH(1), .DEPTH(MS)) u_label_ram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (LAW'(loaded_r)),
    .wdata (in_tdata[16]),
    .re    (lram_re),
    .raddr (LAW'(s_r)),
    .rdata (lbl_rd)
  );

  lrt_sigmoid #(.DEPTH(SIGMOID_TABLE_DEPTH)) u_sigmoid (
    .clk   (clk),
    .z     (acc_r),
    .sig_r (sig)
  );

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_LR:   cfg_prdata = {16'b0, lr_r};
      REG_ITER: cfg_prdata = {16'b0, iter_r};
      REG_FC:   cfg_prdata = {28'b0, fc_r};
      default:  cfg_prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    upd_acc_nxt = upd_acc_r;
    emit_nxt    = emit_r;
    pos_nxt     = pos_r;
    loaded_nxt  = loaded_r;
    lbase_nxt   = lbase_r;
    psum_nxt    = psum_r;
    peos_nxt    = peos_r;
    j_nxt       = j_r;
    it_nxt      = it_r;
    s_nxt       = s_r;
    tbase_nxt   = tbase_r;
    acc_nxt     = acc_r;
    mul_nxt     = mul_r;
    err_nxt     = err_r;
    plo_nxt     = plo_r;
    phi_nxt     = phi_r;
    out_v_nxt   = out_v_r && !out_tready;
    out_w_nxt   = out_w_r;
    out_i_nxt   = out_i_r;
    out_p_nxt   = out_p_r;
    out_k_nxt   = out_k_r;
    out_l_nxt   = out_l_r;
    w_clr       = 1'b0;
    w_we        = 1'b0;
    w_wd        = '0;
    g_clr       = 1'b0;
    g_we        = 1'b0;
    g_wd        = '0;
    ram_we      = 1'b0;
    ram_waddr   = lbase_r + AW'(pos_r);
    ram_wdata   = in_tdata[15:0];
    ram_re      = 1'b0;
    ram_raddr   = tbase_r + AW'(jm1);
    lram_we     = 1'b0;
    lram_re     = 1'b0;
    sum48       = sat48(49'(psum_r) + 49'(mul_r));

    unique case (state_r)
      ST_IDLE: begin
        if (emit_r) begin
          if (out_free) begin
            out_v_nxt = 1'b1;
            out_w_nxt = w_r[j_r];
            out_i_nxt = 4'(j_r);
            out_p_nxt = 1'b0;
            out_k_nxt = KIND_WEIGHT;
            out_l_nxt = (j_r == n_c);
            if (j_r == n_c) begin
              emit_nxt = 1'b0;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
        end else if (in_acc) begin
          unique case (in_tuser)
            ACT_LOAD: begin
              ram_we = !full && pos_lt;
              if (pos_lt) begin
                pos_nxt = pos_r + 1'b1;
              end
              if (in_tlast) begin
                if (!full) begin
                  lram_we = 1'b1;
                  if (32'(pos_r) + 1 < MF) begin
                    state_nxt = ST_FILL;
                  end else begin
                    loaded_nxt = loaded_r + 1'b1;
                    lbase_nxt  = lbase_r + AW'(MF);
                    pos_nxt    = '0;
                  end
                end else begin
                  pos_nxt = '0;
                end
              end
            end
            ACT_TRAIN: begin
              state_nxt = ST_TINIT;
            end
            ACT_PRED: begin
              mul_nxt = (pos_r < n_c) ? w_rd * x_in : 48'sd0;
              if (pos_r == '0) begin
                psum_nxt = {{8{w_r[0][31]}}, w_r[0], 8'h00};
              end
              if (pos_lt) begin
                pos_nxt = pos_r + 1'b1;
              end
              if (in_tlast) begin
                pos_nxt = '0;
              end
              peos_nxt  = in_tlast;
              state_nxt = ST_PACC;
            end
            default: begin
              loaded_nxt = '0;
              pos_nxt    = '0;
              psum_nxt   = '0;
              lbase_nxt  = '0;
            end
          endcase
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (32'(pos_r) == MF - 1) begin
          loaded_nxt = loaded_r + 1'b1;
          lbase_nxt  = lbase_r + AW'(MF);
          pos_nxt    = '0;
          state_nxt  = ST_IDLE;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      ST_PACC: begin
        if (peos_r) begin
          out_v_nxt = 1'b1;
          out_w_nxt = '0;
          out_i_nxt = '0;
          out_p_nxt = !sum48[47];
          out_k_nxt = KIND_PRED;
          out_l_nxt = 1'b1;
          psum_nxt  = '0;
        end else begin
          psum_nxt = sum48;
        end
        state_nxt = ST_IDLE;
      end
      ST_TINIT: begin
        w_clr  = 1'b1;
        it_nxt = '0;
        j_nxt  = '0;
        if (iter_r == '0) begin
          emit_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        g_clr       = 1'b1;
        s_nxt       = '0;
        tbase_nxt   = '0;
        j_nxt       = '0;
        upd_acc_nxt = 1'b0;
        state_nxt   = (loaded_r == '0) ? ST_UPD : ST_SAMP;
      end
      ST_SAMP: begin
        lram_re   = 1'b1;
        acc_nxt   = '0;
        j_nxt     = '0;
        state_nxt = ST_DRD;
      end
      ST_DRD: begin
        ram_re    = (j_r != '0);
        state_nxt = ST_DMUL;
      end
      ST_DMUL: begin
        mul_nxt   = w_rd * opnd;
        state_nxt = ST_DACC;
      end
      ST_DACC: begin
        acc_nxt = sat48(49'(acc_r) + 49'(mul_r));
        if (j_r == n_c) begin
          state_nxt = ST_SIG0;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_DRD;
        end
      end
      ST_SIG0: begin
        state_nxt = ST_SIG1;
      end
      ST_SIG1: begin
        state_nxt = ST_SIG2;
      end
      ST_SIG2: begin
        err_nxt   = lbl_rd ? 18'sd65536 - signed'({1'b0, sig}) : -signed'({1'b0, sig});
        j_nxt     = '0;
        state_nxt = ST_GRD;
      end
      ST_GRD: begin
        ram_re    = (j_r != '0);
        state_nxt = ST_GMUL;
      end
      ST_GMUL: begin
        mul_nxt   = err_r * opnd;
        state_nxt = ST_GACC;
      end
      ST_GACC: begin
        g_we = 1'b1;
        g_wd = sat48(49'(g_rd) + 49'(mul_r));
        if (j_r == n_c) begin
          s_nxt     = s_r + 1'b1;
          tbase_nxt = tbase_r + AW'(MF);
          j_nxt     = '0;
          if (32'(s_r) + 1 == 32'(loaded_r)) begin
            upd_acc_nxt = 1'b0;
            state_nxt   = ST_UPD;
          end else begin
            state_nxt = ST_SAMP;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_GRD;
        end
      end
      ST_UPD: begin
        if (!upd_acc_r) begin
          plo_nxt     = 40'(lr_r) * 40'(g_rd[23:0]);
          phi_nxt     = signed'({1'b0, lr_r}) * signed'(g_rd[47:24]);
          upd_acc_nxt = 1'b1;
        end else begin
          upd_acc_nxt = 1'b0;
          w_we = 1'b1;
          w_wd = sat32(43'(w_rd) + 43'(phi_r) + signed'({27'b0, plo_r[39:24]}));
          if (j_r == n_c) begin
            j_nxt  = '0;
            it_nxt = it_r + 1'b1;
            if (17'(it_r) + 17'd1 == 17'(iter_r)) begin
              emit_nxt  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_ITER;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      upd_acc_r <= 1'b0;
      emit_r    <= 1'b0;
      lr_r      <= LR_RST;
      iter_r    <= ITER_RST;
      fc_r      <= FC_RST;
      pos_r     <= '0;
      loaded_r  <= '0;
      lbase_r   <= '0;
      psum_r    <= '0;
      out_v_r   <= 1'b0;
      for (int k = 0; k <= MF; k++) begin
        w_r[k] <= '0;
        g_r[k] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      upd_acc_r <= upd_acc_nxt;
      emit_r    <= emit_nxt;
      pos_r     <= pos_nxt;
      loaded_r  <= loaded_nxt;
      lbase_r   <= lbase_nxt;
      psum_r    <= psum_nxt;
      out_v_r   <= out_v_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_LR:   lr_r   <= cfg_pwdata[15:0];
          REG_ITER: iter_r <= cfg_pwdata[15:0];
          REG_FC:   fc_r   <= cfg_pwdata[3:0];
          default: begin
          end
        endcase
      end
      if (w_clr) begin
        for (int k = 0; k <= MF; k++) begin
          w_r[k] <= '0;
        end
      end else if (w_we) begin
        w_r[j_r] <= w_wd;
      end
      if (g_clr) begin
        for (int k = 0; k <= MF; k++) begin
          g_r[k] <= '0;
        end
      end else if (g_we) begin
        g_r[j_r] <= g_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    peos_r  <= peos_nxt;
    j_r     <= j_nxt;
    it_r    <= it_nxt;
    s_r     <= s_nxt;
    tbase_r <= tbase_nxt;
    acc_r   <= acc_nxt;
    mul_r   <= mul_nxt;
    err_r   <= err_nxt;
    plo_r   <= plo_nxt;
    phi_r   <= phi_nxt;
    out_w_r <= out_w_nxt;
    out_i_r <= out_i_nxt;
    out_p_r <= out_p_nxt;
    out_k_r <= out_k_nxt;
    out_l_r <= out_l_nxt;
  end

endmodule
